FILE: sv/at_response_matcher_defines.svh
// Assertion macros shared by the AT response matcher checker.
// Needs a clock named clock and a reset named reset in the scope of use.
`ifndef AT_RESPONSE_MATCHER_DEFINES_SVH
`define AT_RESPONSE_MATCHER_DEFINES_SVH

// Checked on every edge outside of reset.
`define ATRM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define ATRM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/atrm_pkg.sv
// Shared types and constants of the AT response matcher.
// Used by every module of the block; depends on nothing.
package atrm_pkg;

   // Default sizes of the line counter and the search window.
   localparam int LINE_MAX_DEF    = 256;
   localparam int PATTERN_MAX_DEF = 16;

   // Number of expected characters held by the two text registers.
   localparam int EXPECT_CHARS = 16;

   // Entries of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;

   // Input mode codes.
   localparam logic [1:0] MODE_BYTE  = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_START = 2'd2;

   // Result outcome codes.
   localparam logic [1:0] OUTCOME_MATCH   = 2'd0;
   localparam logic [1:0] OUTCOME_ERROR   = 2'd1;
   localparam logic [1:0] OUTCOME_TIMEOUT = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_EXPECT_LOW  = 2'd0;
   localparam logic [1:0] CSR_EXPECT_HIGH = 2'd1;
   localparam logic [1:0] CSR_EXPECT_LEN  = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT     = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [4:0]  EXPECT_LEN_RST = 5'd2;
   localparam logic [15:0] TIMEOUT_RST    = 16'd10000;

   // Special characters.
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // The error keyword, first character at index 0.
   localparam int ERR_LEN = 5;
   localparam logic [7:0] ERR_TEXT [ERR_LEN] = '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};

   // Classified work for the back part.
   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_CHAR  = 2'd2,
      KIND_EOL   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] ch;
   } item_type;

   // Configuration as seen by the back part.
   typedef struct packed {
      logic [63:0] expect_low;
      logic [63:0] expect_high;
      logic [4:0]  expect_length;
      logic [15:0] timeout_ticks;
   } cfg_type;

endpackage

FILE: sv/atrm_front.sv
// Front part of the AT response matcher: decodes each input beat.
// Depends on atrm_pkg for the mode codes and the item type.
module atrm_front (
   input  logic [1:0]        mode,
   input  logic [7:0]        rx_byte,
   output logic              keep,
   output atrm_pkg::item_type item
);

   // Carriage returns and the unused mode have no effect and are dropped here.
   always_comb begin
      keep      = 1'b1;
      item.ch   = rx_byte;
      item.kind = atrm_pkg::KIND_CHAR;
      case (mode)
         atrm_pkg::MODE_START: begin
            item.kind = atrm_pkg::KIND_START;
         end
         atrm_pkg::MODE_TICK: begin
            item.kind = atrm_pkg::KIND_TICK;
         end
         atrm_pkg::MODE_BYTE: begin
            if (rx_byte == atrm_pkg::CHAR_CR) begin
               keep = 1'b0;
            end else if (rx_byte == atrm_pkg::CHAR_LF) begin
               item.kind = atrm_pkg::KIND_EOL;
            end
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

endmodule

FILE: sv/atrm_queue.sv
// Short queue of classified items between the front and the back.
// Depends on atrm_pkg for the item type and the queue depth.
module atrm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  atrm_pkg::item_type push_item,
   input  logic               pop,
   output atrm_pkg::item_type head_item,
   output logic               empty,
   output logic               full
);

   localparam int PTR_W = $clog2(atrm_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(atrm_pkg::QUEUE_DEPTH + 1);

   atrm_pkg::item_type slot_ff [atrm_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CNT_W'(atrm_pkg::QUEUE_DEPTH));
   assign head_item = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: sv/atrm_back.sv
// Back part of the AT response matcher: line tracking, text search,
// timeout count and the result register. Depends on atrm_pkg.
module atrm_back #(
   parameter int LINE_MAX    = atrm_pkg::LINE_MAX_DEF,
   parameter int PATTERN_MAX = atrm_pkg::PATTERN_MAX_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  atrm_pkg::cfg_type  cfg,
   input  logic               q_empty,
   input  atrm_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic [1:0]         rsp_tuser
);

   localparam int CNT_W  = $clog2(LINE_MAX);
   localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
   localparam int PIDX_W = $clog2(PATTERN_MAX);
   localparam int EL_W   = (LEN_W > 5) ? LEN_W : 5;
   localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int EXT_W  = (CNT_W > 8) ? CNT_W : 8;

   // Line state.
   logic              waiting_ff, waiting_in;
   logic [15:0]       ticks_ff, ticks_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              expect_seen_ff, expect_seen_in;
   logic              error_seen_ff, error_seen_in;
   logic [7:0]        recent_ff [PATTERN_MAX];
   logic [7:0]        win [PATTERN_MAX];

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_outcome_ff;
   logic [7:0]        rsp_len_ff;

   // Per-item decisions.
   logic              res_valid;
   logic [1:0]        res_outcome;
   logic [7:0]        res_len;
   logic              clear_line;
   logic              push_char;
   logic [7:0]        pat [PATTERN_MAX];
   logic [EL_W-1:0]   elen_ext;
   logic [LEN_W-1:0]  plen;
   logic [CNT_W-1:0]  count_next;
   logic [LEN_W-1:0]  pidx [PATTERN_MAX];
   logic              hit_expect;
   logic              hit_error;
   logic [EXT_W-1:0]  count_ext;
   logic [7:0]        line_len;
   logic [15:0]       tick_next;

   // The back takes an item whenever the result register can hold a new beat.
   assign q_pop = !q_empty && (!rsp_valid_ff || rsp_tready);

   // Expected characters; places past the register pair read as zero.
   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         if (j < 8) begin
            pat[j] = cfg.expect_low[8*j +: 8];
         end else if (j < atrm_pkg::EXPECT_CHARS) begin
            pat[j] = cfg.expect_high[8*(j-8) +: 8];
         end else begin
            pat[j] = 8'h00;
         end
      end
   end

   // Effective pattern length, limited to the window depth.
   assign elen_ext = EL_W'(cfg.expect_length);
   assign plen     = (elen_ext > EL_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                     : LEN_W'(elen_ext);

   // Window after the incoming character is shifted in, newest at index 0.
   always_comb begin
      win[0] = q_item.ch;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         win[k] = recent_ff[k-1];
      end
   end

   assign count_next = count_ff + 1'b1;
   assign push_char  = (count_ff < CNT_W'(LINE_MAX - 1));

   // The window's place k holds pattern character plen-1-k.
   always_comb begin
      hit_expect = (plen != '0) && (CMP_W'(count_next) >= CMP_W'(plen));
      for (int k = 0; k < PATTERN_MAX; k++) begin
         pidx[k] = plen - LEN_W'(k) - 1'b1;
         if (LEN_W'(k) < plen) begin
            if (win[k] != pat[pidx[k][PIDX_W-1:0]]) begin
               hit_expect = 1'b0;
            end
         end
      end
   end

   // Error keyword ends at the newest character.
   always_comb begin
      hit_error = (count_next >= CNT_W'(atrm_pkg::ERR_LEN));
      for (int i = 0; i < atrm_pkg::ERR_LEN; i++) begin
         if (win[atrm_pkg::ERR_LEN - 1 - i] != atrm_pkg::ERR_TEXT[i]) begin
            hit_error = 1'b0;
         end
      end
   end

   // Reported length saturates at 255.
   assign count_ext = EXT_W'(count_ff);
   assign line_len  = (count_ext > EXT_W'(255)) ? 8'hFF : count_ext[7:0];
   assign tick_next = (ticks_ff != 16'd0) ? ticks_ff - 16'd1 : 16'd0;

   // Item execution.
   always_comb begin
      waiting_in     = waiting_ff;
      ticks_in       = ticks_ff;
      count_in       = count_ff;
      expect_seen_in = expect_seen_ff;
      error_seen_in  = error_seen_ff;
      res_valid      = 1'b0;
      res_outcome    = atrm_pkg::OUTCOME_MATCH;
      res_len        = 8'd0;
      clear_line     = 1'b0;
      if (q_pop) begin
         case (q_item.kind)
            atrm_pkg::KIND_START: begin
               waiting_in = 1'b1;
               ticks_in   = cfg.timeout_ticks;
               clear_line = 1'b1;
            end
            atrm_pkg::KIND_TICK: begin
               if (waiting_ff) begin
                  ticks_in = tick_next;
                  if (tick_next == 16'd0) begin
                     res_valid   = 1'b1;
                     res_outcome = atrm_pkg::OUTCOME_TIMEOUT;
                     waiting_in  = 1'b0;
                     clear_line  = 1'b1;
                  end
               end
            end
            atrm_pkg::KIND_CHAR: begin
               if (waiting_ff && push_char) begin
                  count_in = count_next;
                  if (hit_expect) begin
                     expect_seen_in = 1'b1;
                  end
                  if (hit_error) begin
                     error_seen_in = 1'b1;
                  end
               end
            end
            atrm_pkg::KIND_EOL: begin
               if (waiting_ff && count_ff != '0) begin
                  clear_line = 1'b1;
                  res_len    = line_len;
                  if (expect_seen_ff || plen == '0) begin
                     res_valid   = 1'b1;
                     res_outcome = atrm_pkg::OUTCOME_MATCH;
                     waiting_in  = 1'b0;
                  end else if (error_seen_ff) begin
                     res_valid   = 1'b1;
                     res_outcome = atrm_pkg::OUTCOME_ERROR;
                     waiting_in  = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (clear_line) begin
         count_in       = '0;
         expect_seen_in = 1'b0;
         error_seen_in  = 1'b0;
      end
   end

   // A new result loads the register; a taken beat empties it.
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff     <= 1'b0;
         ticks_ff       <= 16'd0;
         count_ff       <= '0;
         expect_seen_ff <= 1'b0;
         error_seen_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         waiting_ff     <= waiting_in;
         ticks_ff       <= ticks_in;
         count_ff       <= count_in;
         expect_seen_ff <= expect_seen_in;
         error_seen_ff  <= error_seen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Window contents are only read once the line holds enough characters.
   always_ff @(posedge clock) begin
      if (q_pop && q_item.kind == atrm_pkg::KIND_CHAR && waiting_ff && push_char) begin
         for (int k = 0; k < PATTERN_MAX; k++) begin
            recent_ff[k] <= win[k];
         end
      end
      if (res_valid) begin
         rsp_outcome_ff <= res_outcome;
         rsp_len_ff     <= res_len;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_len_ff;
   assign rsp_tuser  = rsp_outcome_ff;

endmodule

FILE: sv/at_response_matcher.sv
// AT response matcher top level: configuration registers, front, queue, back.
// Depends on atrm_pkg, atrm_front, atrm_queue and atrm_back.
//
// Usage: the req channel carries one beat per event: a start (arms the wait
// and loads timeout_ticks), a millisecond tick, or a received byte. Bytes are
// gathered into lines; at a line feed a line holding the expected text ends
// the wait with a match, one holding ERROR ends it with an error, others are
// skipped. Ticks count down and end the wait with a timeout at zero.
// The rsp channel gives one beat per finished wait: outcome in rsp_tuser and
// the line length in rsp_tdata.
// The block takes one req beat per cycle while req_tready is high. A deciding
// beat is written into a queue slot, and then the back loads the result
// register from the queue head, which raises rsp_tvalid. Beats still waiting
// ahead of it in the queue delay the result further.
// When the rsp receiver stalls, the back holds its result and stops reading
// the four-entry queue; req_tready falls once the queue is full.
// Reset empties the queue, drops any pending result, ends any wait and
// restores the configuration defaults. csr writes are registered before the back sees them.
module at_response_matcher #(
   parameter int LINE_MAX    = atrm_pkg::LINE_MAX_DEF,
   parameter int PATTERN_MAX = atrm_pkg::PATTERN_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request beats.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // Result beats.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] line_length
   output logic [1:0]  rsp_tuser,   // [1:0] outcome
   // Configuration writes.
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   atrm_pkg::cfg_type  cfg_ff, cfg_in;
   atrm_pkg::item_type front_item;
   atrm_pkg::item_type head_item;
   logic               front_keep;
   logic               q_push;
   logic               q_pop;
   logic               q_empty;
   logic               q_full;

   // Configuration register file.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            atrm_pkg::CSR_EXPECT_LOW:  cfg_in.expect_low    = csr_wdata;
            atrm_pkg::CSR_EXPECT_HIGH: cfg_in.expect_high   = csr_wdata;
            atrm_pkg::CSR_EXPECT_LEN:  cfg_in.expect_length = csr_wdata[4:0];
            atrm_pkg::CSR_TIMEOUT:     cfg_in.timeout_ticks = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expect_low    <= 64'd0;
         cfg_ff.expect_high   <= 64'd0;
         cfg_ff.expect_length <= atrm_pkg::EXPECT_LEN_RST;
         cfg_ff.timeout_ticks <= atrm_pkg::TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: classify accepted beats.
   atrm_front u_front (
      .mode    (req_tuser),
      .rx_byte (req_tdata),
      .keep    (front_keep),
      .item    (front_item)
   );

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready && front_keep;

   atrm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .head_item (head_item),
      .empty     (q_empty),
      .full      (q_full)
   );

   // Back: line state and result register.
   atrm_back #(
      .LINE_MAX    (LINE_MAX),
      .PATTERN_MAX (PATTERN_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: sv/atrm_checker.sv
// Port-level checks of the AT response matcher, bound to the top level.
// Depends on atrm_pkg and at_response_matcher_defines.svh.
`include "at_response_matcher_defines.svh"

module atrm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A stalled result beat keeps its payload.
   `ATRM_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp beat changed while stalled")

   // Leaving reset, no result is pending and the queue takes beats.
   `ATRM_ASSERT_ALWAYS(a_reset_clean, $past(reset) |-> !rsp_tvalid && req_tready, "state not cleared by reset")

   // A timeout reports no line.
   `ATRM_ASSERT(a_timeout_len, rsp_tvalid && rsp_tuser == atrm_pkg::OUTCOME_TIMEOUT |-> rsp_tdata == 8'd0, "timeout with nonzero length")

   // A line-based result always comes from a non-empty line.
   `ATRM_ASSERT(a_line_len, rsp_tvalid && rsp_tuser != atrm_pkg::OUTCOME_TIMEOUT |-> rsp_tdata != 8'd0, "line result with empty line")

endmodule

bind at_response_matcher atrm_checker u_atrm_checker (.*);

FILE: sim/at_response_matcher_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the AT response matcher. It watches the req, rsp and csr ports,
// predicts how each wait ends, and compares every rsp beat with that prediction.
// Depends on atrm_pkg.
module at_response_matcher_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [7:0] line_length
   input  logic [1:0]  rsp_tuser,   // [1:0] outcome
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output int          fail_count,
   output int          outstanding
);

   localparam int WINDOW     = atrm_pkg::PATTERN_MAX_DEF;
   localparam int LINE_LIMIT = atrm_pkg::LINE_MAX_DEF - 1;

   typedef struct packed {
      logic [1:0] outcome;
      logic [7:0] line_length;
   } reply_type;

   // Shadow of the configuration registers.
   logic [63:0] text_low;
   logic [63:0] text_high;
   logic [4:0]  text_len;
   logic [15:0] wait_ticks;

   // Shadow of the matcher state; window[0] holds the newest character.
   logic        armed;
   logic [15:0] ticks_left;
   logic [7:0]  line_count;
   logic [7:0]  window [WINDOW];
   logic        text_seen;
   logic        error_seen;

   // Replies predicted but not yet seen on rsp, oldest first.
   reply_type   pending_replies [$];

   function automatic logic [7:0] text_char(int i);
      if (i < 8) begin
         return text_low[8*i +: 8];
      end
      if (i < 16) begin
         return text_high[8*(i-8) +: 8];
      end
      return 8'h00;
   endfunction

   // An expected-text length beyond the window is cut to the window size.
   function automatic int text_span();
      return (text_len > WINDOW) ? WINDOW : int'(text_len);
   endfunction

   task automatic clear_line();
      line_count = '0;
      for (int i = 0; i < WINDOW; i++) window[i] = '0;
      text_seen  = 1'b0;
      error_seen = 1'b0;
   endtask

   // Store one character and search the window for both texts.
   task automatic take_char(logic [7:0] c);
      int   span;
      logic hit;
      if (line_count < LINE_LIMIT) begin
         for (int i = WINDOW - 1; i > 0; i--) window[i] = window[i - 1];
         window[0]  = c;
         line_count = line_count + 8'd1;
         span = text_span();
         if (span > 0 && line_count >= span) begin
            hit = 1'b1;
            for (int i = 0; i < span; i++) begin
               if (text_char(i) != window[span - 1 - i]) hit = 1'b0;
            end
            if (hit) text_seen = 1'b1;
         end
         if (line_count >= atrm_pkg::ERR_LEN) begin
            hit = 1'b1;
            for (int i = 0; i < atrm_pkg::ERR_LEN; i++) begin
               if (atrm_pkg::ERR_TEXT[i] != window[atrm_pkg::ERR_LEN - 1 - i]) hit = 1'b0;
            end
            if (hit) error_seen = 1'b1;
         end
      end
   endtask

   // Advance the shadow state by one req beat and queue the reply it causes.
   task automatic predict_reply(logic [1:0] mode, logic [7:0] c);
      reply_type r;
      logic      match;
      if (mode == atrm_pkg::MODE_START) begin
         armed      = 1'b1;
         ticks_left = wait_ticks;
         clear_line();
      end else if (armed && mode == atrm_pkg::MODE_TICK) begin
         if (ticks_left != 0) ticks_left = ticks_left - 16'd1;
         if (ticks_left == 0) begin
            armed = 1'b0;
            clear_line();
            r.outcome     = atrm_pkg::OUTCOME_TIMEOUT;
            r.line_length = '0;
            pending_replies.push_back(r);
         end
      end else if (armed && mode == atrm_pkg::MODE_BYTE && c != atrm_pkg::CHAR_CR) begin
         if (c != atrm_pkg::CHAR_LF) begin
            take_char(c);
         end else if (line_count != 0) begin
            // A match wins over ERROR; lines with neither are skipped.
            match = text_seen || text_span() == 0;
            r.outcome     = match ? atrm_pkg::OUTCOME_MATCH : atrm_pkg::OUTCOME_ERROR;
            r.line_length = line_count;
            if (match || error_seen) begin
               armed = 1'b0;
               pending_replies.push_back(r);
            end
            clear_line();
         end
      end
   endtask

   task automatic check_reply();
      reply_type want;
      if (pending_replies.size() == 0) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("%0t: unexpected reply beat, outcome %0d length %0d",
                     $time, rsp_tuser, rsp_tdata);
         end
      end else begin
         want = pending_replies.pop_front();
         if (rsp_tuser !== want.outcome || rsp_tdata !== want.line_length) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("%0t: reply mismatch, expected outcome %0d length %0d, got %0d %0d",
                        $time, want.outcome, want.line_length, rsp_tuser, rsp_tdata);
            end
         end
      end
   endtask

   // Everything is sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (reset) begin
         text_low   = '0;
         text_high  = '0;
         text_len   = atrm_pkg::EXPECT_LEN_RST;
         wait_ticks = atrm_pkg::TIMEOUT_RST;
         armed      = 1'b0;
         ticks_left = '0;
         clear_line();
         pending_replies.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               atrm_pkg::CSR_EXPECT_LOW:  text_low   = csr_wdata;
               atrm_pkg::CSR_EXPECT_HIGH: text_high  = csr_wdata;
               atrm_pkg::CSR_EXPECT_LEN:  text_len   = csr_wdata[4:0];
               atrm_pkg::CSR_TIMEOUT:     wait_ticks = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) check_reply();
         if (req_tvalid && req_tready) predict_reply(req_tuser, req_tdata);
      end
      outstanding <= pending_replies.size();
   end

endmodule

FILE: sim/at_response_matcher_tb.sv
`timescale 1ns / 100ps
// Testbench top of the AT response matcher: clock, reset, register setup,
// req stimulus, rsp back-pressure and the verdict.
// Depends on atrm_pkg, at_response_matcher and at_response_matcher_checker.
module at_response_matcher_tb;

   // Mode code that the block must ignore.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 850;
   localparam int PHASES       = 6;

   typedef enum int {
      LINE_PLAIN,
      LINE_BLANK,
      LINE_TEXT,
      LINE_ERROR,
      LINE_BOTH,
      LINE_LONG
   } line_kind_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [63:0] csr_wdata  = '0;
   int          fail_count;
   int          outstanding;

   // Copy of the programmed expected text, used to build matching lines.
   logic [7:0]  want_text [16];
   int          want_len;
   bit          quiet;        // no gaps and no new stalls while set
   int          sent;
   int          long_lines;
   int          stall_left;

   always #4 clock = ~clock;

   at_response_matcher dut (.*);

   at_response_matcher_checker checker_i (.*);

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Mostly no gap, some short ones, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 70) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      if (r < 98) begin
         return $urandom_range(4, 8);
      end
      return $urandom_range(15, 40);
   endfunction

   // Result receiver: random stalls, mostly short.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < 12) begin
         rsp_tready = 1'b0;
         stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                 : $urandom_range(10, 40);
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_beat(logic [1:0] mode, logic [7:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = data;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent++;
   endtask

   task automatic write_reg(logic [1:0] index, logic [63:0] value);
      csr_index = index;
      csr_wdata = value;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic program_matcher(logic [127:0] chars, logic [4:0] len, logic [15:0] ticks);
      write_reg(atrm_pkg::CSR_EXPECT_LOW, chars[63:0]);
      write_reg(atrm_pkg::CSR_EXPECT_HIGH, chars[127:64]);
      write_reg(atrm_pkg::CSR_EXPECT_LEN, {59'd0, len});
      write_reg(atrm_pkg::CSR_TIMEOUT, {48'd0, ticks});
      for (int i = 0; i < 16; i++) want_text[i] = chars[8*i +: 8];
      want_len = (len > 16) ? 16 : int'(len);
   endtask

   function automatic logic [127:0] text_bits(string s);
      logic [127:0] bits;
      bits = '0;
      for (int i = 0; i < s.len() && i < 16; i++) bits[8*i +: 8] = s[i];
      return bits;
   endfunction

   // Wait until every predicted reply is out and the internal queue has drained.
   task automatic settle();
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_beat(atrm_pkg::MODE_BYTE, s[i]);
   endtask

   // Any byte except a line feed, which would end the line early.
   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      b = $urandom_range(0, 255);
      if (b == atrm_pkg::CHAR_LF) b = 8'h20;
      return b;
   endfunction

   // One line of the given kind, with stray CRs and ticks mixed in.
   task automatic send_line(line_kind_type kind, int tick_pct);
      logic [7:0] body [$];
      int         pad;
      bit         text_first;
      pad = (kind == LINE_LONG) ? $urandom_range(240, 300) : $urandom_range(0, 5);
      if (kind == LINE_BLANK) pad = 0;
      text_first = $urandom_range(0, 1);
      for (int i = 0; i < pad; i++) body.push_back(body_byte());
      if (kind == LINE_ERROR || (kind == LINE_BOTH && !text_first)) begin
         for (int i = 0; i < atrm_pkg::ERR_LEN; i++) body.push_back(atrm_pkg::ERR_TEXT[i]);
      end
      if (kind == LINE_TEXT || kind == LINE_BOTH || (kind == LINE_LONG && text_first)) begin
         for (int i = 0; i < want_len; i++) body.push_back(want_text[i]);
      end
      if (kind == LINE_BOTH && text_first) begin
         for (int i = 0; i < atrm_pkg::ERR_LEN; i++) body.push_back(atrm_pkg::ERR_TEXT[i]);
      end
      if (kind != LINE_BLANK && $urandom_range(0, 1)) begin
         repeat ($urandom_range(1, 3)) body.push_back(body_byte());
      end
      foreach (body[i]) begin
         if ($urandom_range(0, 99) < 8) send_beat(atrm_pkg::MODE_BYTE, atrm_pkg::CHAR_CR);
         if ($urandom_range(0, 99) < tick_pct) send_beat(atrm_pkg::MODE_TICK, body_byte());
         send_beat(atrm_pkg::MODE_BYTE, body[i]);
      end
      if ($urandom_range(0, 1)) send_beat(atrm_pkg::MODE_BYTE, atrm_pkg::CHAR_CR);
      send_beat(atrm_pkg::MODE_BYTE, atrm_pkg::CHAR_LF);
   endtask

   // A start followed by a few lines; the last one usually decides the wait.
   task automatic run_session(int tick_pct);
      int            lines;
      int            pick;
      line_kind_type kind;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 3)) send_beat(2'($urandom_range(0, 3)), body_byte());
      end
      send_beat(atrm_pkg::MODE_START, body_byte());
      if ($urandom_range(0, 6) == 0) begin
         repeat ($urandom_range(1, 60)) send_beat(atrm_pkg::MODE_TICK, body_byte());
      end
      lines = $urandom_range(1, 4);
      for (int k = 0; k < lines; k++) begin
         if ($urandom_range(0, 99) < 4) send_beat(atrm_pkg::MODE_START, body_byte());
         if ($urandom_range(0, 99) < 3) send_beat(MODE_UNUSED, body_byte());
         if (k < lines - 1) begin
            kind = ($urandom_range(0, 99) < 60) ? LINE_PLAIN : LINE_BLANK;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 40) kind = LINE_TEXT;
            else if (pick < 65) kind = LINE_ERROR;
            else if (pick < 80) kind = LINE_BOTH;
            else if (pick < 90) kind = LINE_PLAIN;
            else if (pick < 95 || long_lines >= 4) kind = LINE_BLANK;
            else begin
               kind = LINE_LONG;
               long_lines++;
            end
         end
         send_line(kind, tick_pct);
      end
   endtask

   initial begin
      int goal;
      int tick_pct;
      for (int i = 0; i < 16; i++) want_text[i] = 8'h00;
      want_len = 2;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Default registers: expected text is two zero bytes.
      // Beats while idle and the unused mode are dropped.
      send_beat(atrm_pkg::MODE_BYTE, "x");
      send_beat(atrm_pkg::MODE_TICK, 8'h00);
      send_beat(MODE_UNUSED, 8'hFF);
      send_beat(atrm_pkg::MODE_START, 8'h00);
      send_beat(atrm_pkg::MODE_BYTE, 8'h00);
      send_beat(atrm_pkg::MODE_BYTE, 8'h00);
      send_beat(atrm_pkg::MODE_BYTE, atrm_pkg::CHAR_LF);
      settle();

      // Blank line skipped, then an ERROR line; then a restart and a timeout.
      program_matcher(text_bits("OK"), 5'd2, 16'd3);
      send_beat(atrm_pkg::MODE_START, 8'hFF);
      send_beat(atrm_pkg::MODE_BYTE, atrm_pkg::CHAR_CR);
      send_beat(atrm_pkg::MODE_BYTE, atrm_pkg::CHAR_LF);
      send_text("ERROR");
      send_beat(atrm_pkg::MODE_BYTE, atrm_pkg::CHAR_LF);
      send_beat(atrm_pkg::MODE_START, 8'h00);
      send_beat(atrm_pkg::MODE_BYTE, "A");
      send_beat(atrm_pkg::MODE_START, 8'h00);
      repeat (3) send_beat(atrm_pkg::MODE_TICK, 8'h00);

      // Random sessions under several register settings.
      for (int p = 0; p < PHASES; p++) begin
         settle();
         quiet    = 1'b0;
         tick_pct = 2;
         case (p)
            0: begin
               program_matcher(text_bits("OK"), 5'd2, 16'd40);
               tick_pct = 4;
            end
            1: begin
               program_matcher({$urandom, $urandom, $urandom, $urandom},
                               5'($urandom_range(1, 16)), 16'($urandom_range(20, 200)));
               tick_pct = 3;
            end
            2: begin
               quiet = 1'b1;
               program_matcher(text_bits("+CREG: 0,1 READY"), 5'd16, 16'hFFFF);
            end
            3: program_matcher({$urandom, $urandom, $urandom, $urandom}, 5'd0, 16'd0);
            4: begin
               program_matcher({$urandom, $urandom, $urandom, $urandom}, 5'd31, 16'd1);
               tick_pct = 1;
            end
            default: begin
               program_matcher({16{8'hFF}}, 5'd1, 16'd500);
               tick_pct = 5;
            end
         endcase
         goal = sent + RANDOM_ITEMS / PHASES;
         while (sent < goal) run_session(tick_pct);
      end

      // Drain and let any stray reply show up before the verdict.
      quiet = 1'b1;
      settle();
      repeat (40) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
